[rtl/ofip_pkg.sv]
`timescale 1ns / 1ps

package ofip_pkg;

  // Parse phase codes
  localparam logic [2:0] PH_BETWEEN = 3'd0;
  localparam logic [2:0] PH_START   = 3'd1;
  localparam logic [2:0] PH_SIGNED  = 3'd2;
  localparam logic [2:0] PH_DIGITS  = 3'd3;
  localparam logic [2:0] PH_VSLASH  = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;

  // Line status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_EXPECT_INT = 2'd1;
  localparam logic [1:0] ST_UNDEFINED  = 2'd2;
  localparam logic [1:0] ST_MISMATCH   = 2'd3;

  // Component kind flags
  localparam logic [1:0] HAS_TEX = 2'b01;
  localparam logic [1:0] HAS_NRM = 2'b10;

  // Component slots
  localparam logic [1:0] SLOT_V = 2'd0;
  localparam logic [1:0] SLOT_T = 2'd1;
  localparam logic [1:0] SLOT_N = 2'd2;

  // Characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NEL   = 8'h85;
  localparam logic [7:0] CH_NBSP  = 8'hA0;

  localparam logic [7:0] MIN_TRIADS = 8'd3;
  localparam logic [7:0] TOTAL_MAX  = 8'hFF;

  // Per-line parser control state
  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] slot;
    logic [2:0] neg;
    logic [1:0] present;
    logic [1:0] required;
    logic [7:0] count;
    logic [1:0] err;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    phase:    PH_BETWEEN,
    slot:     SLOT_V,
    neg:      3'b000,
    present:  2'b00,
    required: 2'b00,
    count:    8'd0,
    err:      ST_OK
  };

  // Result flags carried beside the three indices
  typedef struct packed {
    logic       triad_valid;
    logic       has_tex;
    logic       has_nrm;
    logic       line_done;
    logic [1:0] status;
    logic [7:0] total;
  } res_t;

endpackage

[rtl/ofip_step.sv]
`timescale 1ns / 1ps

// Per-character parse step: classify, accumulate, resolve, pick result
module ofip_step #(
  parameter int INDEX_BITS = 24
) (
  input  ofip_pkg::ctl_t                       ctl_i,
  input  logic [2:0][INDEX_BITS:0]             acc_i,
  input  logic [7:0]                           char_code_i,
  input  logic                                 end_of_line_i,
  input  logic [INDEX_BITS-1:0]                vertex_count_i,
  input  logic [INDEX_BITS-1:0]                texcoord_count_i,
  input  logic [INDEX_BITS-1:0]                normal_count_i,
  output ofip_pkg::ctl_t                       ctl_o,
  output logic [2:0][INDEX_BITS:0]             acc_o,
  output ofip_pkg::res_t                       res_o,
  output logic [INDEX_BITS-1:0]                vertex_index_o,
  output logic [INDEX_BITS-1:0]                texcoord_index_o,
  output logic [INDEX_BITS-1:0]                normal_index_o,
  output logic                                 emit_o
);

  localparam int MAG_W  = INDEX_BITS + 1;
  localparam int PROD_W = MAG_W + 4;

  // first error sticks
  function automatic logic [1:0] first_err(input logic [1:0] cur, input logic [1:0] code);
    first_err = (cur == ofip_pkg::ST_OK) ? code : cur;
  endfunction

  logic                            is_digit;
  logic                            is_sign;
  logic                            is_space;
  logic                            is_slash;
  logic [3:0]                      digit_val;

  // character classes
  always_comb begin
    is_digit  = (char_code_i >= ofip_pkg::CH_ZERO) && (char_code_i <= ofip_pkg::CH_NINE);
    is_sign   = (char_code_i == ofip_pkg::CH_PLUS) || (char_code_i == ofip_pkg::CH_MINUS);
    is_space  = ((char_code_i >= ofip_pkg::CH_TAB) && (char_code_i <= ofip_pkg::CH_CR)) ||
                (char_code_i == ofip_pkg::CH_SPACE) || (char_code_i == ofip_pkg::CH_NEL) ||
                (char_code_i == ofip_pkg::CH_NBSP);
    is_slash  = (char_code_i == ofip_pkg::CH_SLASH);
    digit_val = 4'(char_code_i - ofip_pkg::CH_ZERO);
  end

  ofip_pkg::ctl_t                  nc;
  logic [2:0][MAG_W-1:0]           nacc;
  logic [2:0][INDEX_BITS-1:0]      cnt;
  logic [2:0][INDEX_BITS-1:0]      idx;
  logic [2:0]                      ok;
  logic [1:0]                      sel;
  logic [MAG_W-1:0]                cur_acc;
  logic [PROD_W-1:0]               prod;
  logic [MAG_W-1:0]                cntx;
  logic [MAG_W-1:0]                diff;
  logic                            do_num;
  logic                            ended;
  logic                            bad;
  logic                            accept;

  assign cnt[0] = vertex_count_i;
  assign cnt[1] = texcoord_count_i;
  assign cnt[2] = normal_count_i;

  always_comb begin
    nc      = ctl_i;
    nacc    = acc_i;
    do_num  = 1'b0;
    ended   = 1'b0;
    bad     = 1'b0;
    accept  = 1'b0;
    sel     = ofip_pkg::SLOT_V;
    cur_acc = '0;
    prod    = '0;
    cntx    = '0;
    diff    = '0;
    ok      = '0;
    idx     = '0;
    res_o   = '0;
    emit_o  = 1'b0;
    vertex_index_o   = '0;
    texcoord_index_o = '0;
    normal_index_o   = '0;

    // phase dispatch
    unique case (ctl_i.phase) inside
      ofip_pkg::PH_BETWEEN: begin
        if (!is_space) begin
          nacc       = '0;
          nc.neg     = '0;
          nc.present = '0;
          nc.slot    = ofip_pkg::SLOT_V;
          nc.phase   = ofip_pkg::PH_START;
          do_num     = 1'b1;
        end
      end
      ofip_pkg::PH_START, ofip_pkg::PH_SIGNED, ofip_pkg::PH_DIGITS: begin
        do_num = 1'b1;
      end
      ofip_pkg::PH_VSLASH: begin
        if (is_slash) begin
          nc.present = nc.present | ofip_pkg::HAS_NRM;
          nc.slot    = ofip_pkg::SLOT_N;
          nc.phase   = ofip_pkg::PH_START;
        end else if (is_space) begin
          nc.err   = first_err(nc.err, ofip_pkg::ST_EXPECT_INT);
          nc.phase = ofip_pkg::PH_SKIP;
        end else begin
          nc.present = nc.present | ofip_pkg::HAS_TEX;
          nc.slot    = ofip_pkg::SLOT_T;
          nc.phase   = ofip_pkg::PH_START;
          do_num     = 1'b1;
        end
      end
      default: begin
        nc.phase = ofip_pkg::PH_SKIP;
      end
    endcase

    // one character inside a component
    if (do_num) begin
      sel = (nc.slot == 2'd3) ? ofip_pkg::SLOT_N : nc.slot;
      for (int i = 0; i < 3; i++) begin
        if (sel == 2'(i)) cur_acc = nacc[i];
      end
      if (is_digit) begin
        prod     = (PROD_W'(cur_acc) << 3) + (PROD_W'(cur_acc) << 1) + PROD_W'(digit_val);
        nc.phase = ofip_pkg::PH_DIGITS;
        for (int i = 0; i < 3; i++) begin
          if (sel == 2'(i)) nacc[i] = prod[MAG_W-1:0];
        end
        // magnitude beyond the index range
        if (|prod[PROD_W-1:MAG_W]) begin
          nc.err   = first_err(nc.err, ofip_pkg::ST_EXPECT_INT);
          nc.phase = ofip_pkg::PH_SKIP;
        end
      end else if (is_sign) begin
        if (nc.phase != ofip_pkg::PH_START) begin
          nc.err   = first_err(nc.err, ofip_pkg::ST_EXPECT_INT);
          nc.phase = ofip_pkg::PH_SKIP;
        end else begin
          nc.neg[sel] = (char_code_i == ofip_pkg::CH_MINUS);
          nc.phase    = ofip_pkg::PH_SIGNED;
        end
      end else if (is_space) begin
        if (nc.phase == ofip_pkg::PH_DIGITS) begin
          ended = 1'b1;
        end else begin
          nc.err   = first_err(nc.err, ofip_pkg::ST_EXPECT_INT);
          nc.phase = ofip_pkg::PH_SKIP;
        end
      end else if (is_slash && (nc.phase == ofip_pkg::PH_DIGITS)) begin
        if (sel == ofip_pkg::SLOT_V) begin
          nc.phase = ofip_pkg::PH_VSLASH;
        end else if (sel == ofip_pkg::SLOT_T) begin
          nc.present = nc.present | ofip_pkg::HAS_NRM;
          nc.slot    = ofip_pkg::SLOT_N;
          nc.phase   = ofip_pkg::PH_START;
        end else begin
          // third slash
          nc.err   = first_err(nc.err, ofip_pkg::ST_EXPECT_INT);
          nc.phase = ofip_pkg::PH_SKIP;
        end
      end else begin
        nc.err   = first_err(nc.err, ofip_pkg::ST_EXPECT_INT);
        nc.phase = ofip_pkg::PH_SKIP;
      end
    end

    // end of line closes an open component
    if (!ended && end_of_line_i) begin
      if (nc.phase == ofip_pkg::PH_DIGITS) begin
        ended = 1'b1;
      end else if ((nc.phase != ofip_pkg::PH_BETWEEN) && (nc.phase != ofip_pkg::PH_SKIP)) begin
        nc.err   = first_err(nc.err, ofip_pkg::ST_EXPECT_INT);
        nc.phase = ofip_pkg::PH_SKIP;
      end
    end

    // resolve each slot against its count
    for (int i = 0; i < 3; i++) begin
      cntx   = {1'b0, cnt[i]};
      ok[i]  = (nacc[i] != '0) && (nacc[i] <= cntx);
      diff   = nc.neg[i] ? (cntx - nacc[i]) : (nacc[i] - MAG_W'(1));
      idx[i] = diff[INDEX_BITS-1:0];
    end

    // triad close
    if (ended) begin
      nc.phase = ofip_pkg::PH_BETWEEN;
      bad = !ok[0] ||
            (((nc.present & ofip_pkg::HAS_TEX) != '0) && !ok[1]) ||
            (((nc.present & ofip_pkg::HAS_NRM) != '0) && !ok[2]);
      if (bad) begin
        nc.err   = first_err(nc.err, ofip_pkg::ST_UNDEFINED);
        nc.phase = ofip_pkg::PH_SKIP;
      end else if (nc.count == 8'd0) begin
        nc.required = nc.present;
        accept      = 1'b1;
      end else if (nc.present != nc.required) begin
        nc.err   = first_err(nc.err, ofip_pkg::ST_MISMATCH);
        nc.phase = ofip_pkg::PH_SKIP;
      end else begin
        accept = 1'b1;
      end
    end

    if (accept) begin
      if (nc.count != ofip_pkg::TOTAL_MAX) nc.count = nc.count + 8'd1;
      res_o.triad_valid = 1'b1;
      res_o.has_tex     = (nc.present & ofip_pkg::HAS_TEX) != '0;
      res_o.has_nrm     = (nc.present & ofip_pkg::HAS_NRM) != '0;
      vertex_index_o    = idx[0];
      texcoord_index_o  = res_o.has_tex ? idx[1] : '0;
      normal_index_o    = res_o.has_nrm ? idx[2] : '0;
      emit_o            = 1'b1;
    end

    res_o.total = nc.count;

    // line close: status and state clear
    if (end_of_line_i) begin
      res_o.line_done = 1'b1;
      res_o.status    = ((nc.err == ofip_pkg::ST_OK) && (nc.count < ofip_pkg::MIN_TRIADS)) ?
                        ofip_pkg::ST_EXPECT_INT : nc.err;
      emit_o          = 1'b1;
      nc              = ofip_pkg::CTL_RESET;
      nacc            = '0;
    end
  end

  assign ctl_o = nc;
  assign acc_o = nacc;

endmodule

[rtl/ofip_out_reg.sv]
`timescale 1ns / 1ps

// Result register on the output channel
module ofip_out_reg #(
  parameter int INDEX_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  ofip_pkg::res_t        res_i,
  input  logic [INDEX_BITS-1:0] vertex_index_i,
  input  logic [INDEX_BITS-1:0] texcoord_index_i,
  input  logic [INDEX_BITS-1:0] normal_index_i,
  output logic                  free_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output ofip_pkg::res_t        res_o,
  output logic [INDEX_BITS-1:0] vertex_index_o,
  output logic [INDEX_BITS-1:0] texcoord_index_o,
  output logic [INDEX_BITS-1:0] normal_index_o
);

  logic                  valid_q;
  logic                  valid_d;
  ofip_pkg::res_t        res_q;
  logic [INDEX_BITS-1:0] vidx_q;
  logic [INDEX_BITS-1:0] tidx_q;
  logic [INDEX_BITS-1:0] nidx_q;

  // slot is free when empty or being drained this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q  <= res_i;
      vidx_q <= vertex_index_i;
      tidx_q <= texcoord_index_i;
      nidx_q <= normal_index_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign res_o            = res_q;
  assign vertex_index_o   = vidx_q;
  assign texcoord_index_o = tidx_q;
  assign normal_index_o   = nidx_q;

endmodule

[rtl/obj_face_index_parser.sv]
`timescale 1ns / 1ps

// Face index parser for the text of one OBJ face line, fed one character per beat.
// It takes a character every cycle unless in_stall_o holds it, and produces at most
// one result per character: a resolved triad, a line-closing status, or both on the
// last character. Throughput is one character per cycle while the output does not
// stall, set by the parse loop (character decode, multiply-by-ten accumulate, then
// index range check and resolve) that sits between the input register and the
// result register and updates the line state on every beat.
// Counts and index outputs are INDEX_BITS wide; magnitudes above 2^(INDEX_BITS+1)-1
// report an expected-integer status.
module obj_face_index_parser #(
  parameter int INDEX_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            char_code_i,
  input  logic                  end_of_line_i,
  input  logic [INDEX_BITS-1:0] vertex_count_i,
  input  logic [INDEX_BITS-1:0] texcoord_count_i,
  input  logic [INDEX_BITS-1:0] normal_count_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  triad_valid_o,
  output logic [INDEX_BITS-1:0] vertex_index_o,
  output logic [INDEX_BITS-1:0] texcoord_index_o,
  output logic [INDEX_BITS-1:0] normal_index_o,
  output logic                  has_texcoord_o,
  output logic                  has_normal_o,
  output logic                  line_done_o,
  output logic [1:0]            line_status_o,
  output logic [7:0]            triad_total_o
);

  localparam int MAG_W = INDEX_BITS + 1;

  // input register
  logic                  in_valid_q;
  logic                  in_valid_d;
  logic [7:0]            char_q;
  logic                  eol_q;
  logic [INDEX_BITS-1:0] vcnt_q;
  logic [INDEX_BITS-1:0] tcnt_q;
  logic [INDEX_BITS-1:0] ncnt_q;

  // line state
  ofip_pkg::ctl_t        ctl_q;
  ofip_pkg::ctl_t        ctl_d;
  logic [2:0][MAG_W-1:0] acc_q;
  logic [2:0][MAG_W-1:0] acc_d;

  ofip_pkg::res_t        step_res;
  ofip_pkg::res_t        out_res;
  logic [INDEX_BITS-1:0] step_vidx;
  logic [INDEX_BITS-1:0] step_tidx;
  logic [INDEX_BITS-1:0] step_nidx;
  logic                  step_emit;
  logic                  out_free;
  logic                  advance;
  logic                  in_take;

  // beat moves from the input register into the result stage
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      char_q <= char_code_i;
      eol_q  <= end_of_line_i;
      vcnt_q <= vertex_count_i;
      tcnt_q <= texcoord_count_i;
      ncnt_q <= normal_count_i;
    end
  end

  ofip_step #(
    .INDEX_BITS (INDEX_BITS)
  ) u_step (
    .ctl_i            (ctl_q),
    .acc_i            (acc_q),
    .char_code_i      (char_q),
    .end_of_line_i    (eol_q),
    .vertex_count_i   (vcnt_q),
    .texcoord_count_i (tcnt_q),
    .normal_count_i   (ncnt_q),
    .ctl_o            (ctl_d),
    .acc_o            (acc_d),
    .res_o            (step_res),
    .vertex_index_o   (step_vidx),
    .texcoord_index_o (step_tidx),
    .normal_index_o   (step_nidx),
    .emit_o           (step_emit)
  );

  // line state advances once per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= ofip_pkg::CTL_RESET;
      acc_q <= '0;
    end else if (advance) begin
      ctl_q <= ctl_d;
      acc_q <= acc_d;
    end
  end

  ofip_out_reg #(
    .INDEX_BITS (INDEX_BITS)
  ) u_out_reg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (advance && step_emit),
    .res_i            (step_res),
    .vertex_index_i   (step_vidx),
    .texcoord_index_i (step_tidx),
    .normal_index_i   (step_nidx),
    .free_o           (out_free),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .res_o            (out_res),
    .vertex_index_o   (vertex_index_o),
    .texcoord_index_o (texcoord_index_o),
    .normal_index_o   (normal_index_o)
  );

  assign triad_valid_o  = out_res.triad_valid;
  assign has_texcoord_o = out_res.has_tex;
  assign has_normal_o   = out_res.has_nrm;
  assign line_done_o    = out_res.line_done;
  assign line_status_o  = out_res.status;
  assign triad_total_o  = out_res.total;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int IDX_W = 24;
  localparam logic [63:0] MAG_MAX = (64'd1 << (IDX_W + 1)) - 64'd1;

  // One character beat with the counts that travel beside it
  typedef struct packed {
    logic [7:0]       ch;
    logic             eol;
    logic [IDX_W-1:0] vc;
    logic [IDX_W-1:0] tc;
    logic [IDX_W-1:0] nc;
  } face_char_t;

  // One result beat
  typedef struct packed {
    logic             triad_valid;
    logic [IDX_W-1:0] vertex_index;
    logic [IDX_W-1:0] texcoord_index;
    logic [IDX_W-1:0] normal_index;
    logic             has_texcoord;
    logic             has_normal;
    logic             line_done;
    logic [1:0]       line_status;
    logic [7:0]       triad_total;
  } face_res_t;

  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             in_valid_i       = 1'b0;
  logic             in_stall_o;
  logic [7:0]       char_code_i      = '0;
  logic             end_of_line_i    = 1'b0;
  logic [IDX_W-1:0] vertex_count_i   = '0;
  logic [IDX_W-1:0] texcoord_count_i = '0;
  logic [IDX_W-1:0] normal_count_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i      = 1'b0;
  logic             triad_valid_o;
  logic [IDX_W-1:0] vertex_index_o;
  logic [IDX_W-1:0] texcoord_index_o;
  logic [IDX_W-1:0] normal_index_o;
  logic             has_texcoord_o;
  logic             has_normal_o;
  logic             line_done_o;
  logic [1:0]       line_status_o;
  logic [7:0]       triad_total_o;

  obj_face_index_parser #(.INDEX_BITS(IDX_W)) uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_code_i      (char_code_i),
    .end_of_line_i    (end_of_line_i),
    .vertex_count_i   (vertex_count_i),
    .texcoord_count_i (texcoord_count_i),
    .normal_count_i   (normal_count_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .triad_valid_o    (triad_valid_o),
    .vertex_index_o   (vertex_index_o),
    .texcoord_index_o (texcoord_index_o),
    .normal_index_o   (normal_index_o),
    .has_texcoord_o   (has_texcoord_o),
    .has_normal_o     (has_normal_o),
    .line_done_o      (line_done_o),
    .line_status_o    (line_status_o),
    .triad_total_o    (triad_total_o)
  );

  face_char_t char_stream[$];
  face_res_t  face_results_q[$];
  logic [7:0] line_buf[$];

  int err_count     = 0;
  int chars_taken   = 0;
  int results_seen  = 0;
  int triads_seen   = 0;
  int bad_lines     = 0;
  int lines_built   = 0;
  int send_gap      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  bit calm          = 1'b0;

  logic [7:0] ws_chars[8] = '{ofip_pkg::CH_SPACE, ofip_pkg::CH_TAB, 8'h0A, 8'h0B, 8'h0C,
                              ofip_pkg::CH_CR, ofip_pkg::CH_NEL, ofip_pkg::CH_NBSP};

  // Shadow copy of the per-line parser state
  logic [2:0]  sh_phase;
  logic [1:0]  sh_slot;
  logic [63:0] sh_mag[3];
  logic        sh_neg[3];
  logic [1:0]  sh_present;
  logic [1:0]  sh_required;
  logic [7:0]  sh_triads;
  logic [1:0]  sh_err;

  // Clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Face line predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_ws(logic [7:0] c);
    return (c >= ofip_pkg::CH_TAB && c <= ofip_pkg::CH_CR) || c == ofip_pkg::CH_SPACE ||
           c == ofip_pkg::CH_NEL || c == ofip_pkg::CH_NBSP;
  endfunction

  function automatic void flag_error(logic [1:0] code);
    if (sh_err == ofip_pkg::ST_OK) sh_err = code;
    sh_phase = ofip_pkg::PH_SKIP;
  endfunction

  function automatic void clear_triad();
    for (int i = 0; i < 3; i++) begin
      sh_mag[i] = '0;
      sh_neg[i] = 1'b0;
    end
    sh_present = '0;
  endfunction

  function automatic void clear_line();
    clear_triad();
    sh_phase    = ofip_pkg::PH_BETWEEN;
    sh_slot     = ofip_pkg::SLOT_V;
    sh_required = '0;
    sh_triads   = '0;
    sh_err      = ofip_pkg::ST_OK;
  endfunction

  function automatic void start_component(logic [1:0] s);
    sh_slot  = s;
    sh_phase = ofip_pkg::PH_START;
  endfunction

  // One character inside a component; returns 1 when the triad closes
  function automatic bit component_char(logic [7:0] c);
    int s;
    s = (sh_slot > ofip_pkg::SLOT_N) ? 2 : int'(sh_slot);
    if (c >= ofip_pkg::CH_ZERO && c <= ofip_pkg::CH_NINE) begin
      sh_phase = ofip_pkg::PH_DIGITS;
      sh_mag[s] = sh_mag[s] * 64'd10 + 64'(c - ofip_pkg::CH_ZERO);
      if (sh_mag[s] > MAG_MAX) flag_error(ofip_pkg::ST_EXPECT_INT);
      return 1'b0;
    end
    if (c == ofip_pkg::CH_PLUS || c == ofip_pkg::CH_MINUS) begin
      if (sh_phase != ofip_pkg::PH_START) begin
        flag_error(ofip_pkg::ST_EXPECT_INT);
        return 1'b0;
      end
      sh_neg[s] = (c == ofip_pkg::CH_MINUS);
      sh_phase = ofip_pkg::PH_SIGNED;
      return 1'b0;
    end
    if (is_ws(c)) begin
      if (sh_phase == ofip_pkg::PH_DIGITS) return 1'b1;
      flag_error(ofip_pkg::ST_EXPECT_INT);
      return 1'b0;
    end
    if (c == ofip_pkg::CH_SLASH && sh_phase == ofip_pkg::PH_DIGITS) begin
      if (s == 0) begin
        sh_phase = ofip_pkg::PH_VSLASH;
      end else if (s == 1) begin
        sh_present |= ofip_pkg::HAS_NRM;
        start_component(ofip_pkg::SLOT_N);
      end else begin
        flag_error(ofip_pkg::ST_EXPECT_INT);
      end
      return 1'b0;
    end
    flag_error(ofip_pkg::ST_EXPECT_INT);
    return 1'b0;
  endfunction

  // Turns a one-based or negative index into a zero-based one
  function automatic bit resolve_index(int s, logic [IDX_W-1:0] cnt,
                                       output logic [IDX_W-1:0] idx);
    logic [63:0] m;
    logic [63:0] c64;
    m   = sh_mag[s];
    c64 = 64'(cnt);
    idx = '0;
    if (m == 0 || m > c64) return 1'b0;
    idx = sh_neg[s] ? IDX_W'(c64 - m) : IDX_W'(m - 64'd1);
    return 1'b1;
  endfunction

  function automatic bit close_triad(face_char_t it, inout face_res_t r);
    logic [IDX_W-1:0] v, t, n;
    v = '0;
    t = '0;
    n = '0;
    sh_phase = ofip_pkg::PH_BETWEEN;
    if (!resolve_index(0, it.vc, v) ||
        ((sh_present & ofip_pkg::HAS_TEX) != 0 && !resolve_index(1, it.tc, t)) ||
        ((sh_present & ofip_pkg::HAS_NRM) != 0 && !resolve_index(2, it.nc, n))) begin
      flag_error(ofip_pkg::ST_UNDEFINED);
      return 1'b0;
    end
    if (sh_triads == 0) begin
      sh_required = sh_present;
    end else if (sh_present != sh_required) begin
      flag_error(ofip_pkg::ST_MISMATCH);
      return 1'b0;
    end
    if (sh_triads < ofip_pkg::TOTAL_MAX) sh_triads++;
    r.triad_valid    = 1'b1;
    r.vertex_index   = v;
    r.texcoord_index = ((sh_present & ofip_pkg::HAS_TEX) != 0) ? t : '0;
    r.normal_index   = ((sh_present & ofip_pkg::HAS_NRM) != 0) ? n : '0;
    r.has_texcoord   = (sh_present & ofip_pkg::HAS_TEX) != 0;
    r.has_normal     = (sh_present & ofip_pkg::HAS_NRM) != 0;
    return 1'b1;
  endfunction

  // Advances the shadow state by one beat and queues the result it causes
  function automatic void parse_face_char(face_char_t it);
    bit closed;
    bit give;
    face_res_t r;
    logic [1:0] st;
    closed = 1'b0;
    give   = 1'b0;
    r      = '0;
    case (sh_phase)
      ofip_pkg::PH_BETWEEN: begin
        if (!is_ws(it.ch)) begin
          clear_triad();
          start_component(ofip_pkg::SLOT_V);
          closed = component_char(it.ch);
        end
      end
      ofip_pkg::PH_START, ofip_pkg::PH_SIGNED, ofip_pkg::PH_DIGITS: begin
        closed = component_char(it.ch);
      end
      ofip_pkg::PH_VSLASH: begin
        if (it.ch == ofip_pkg::CH_SLASH) begin
          sh_present |= ofip_pkg::HAS_NRM;
          start_component(ofip_pkg::SLOT_N);
        end else if (is_ws(it.ch)) begin
          flag_error(ofip_pkg::ST_EXPECT_INT);
        end else begin
          sh_present |= ofip_pkg::HAS_TEX;
          start_component(ofip_pkg::SLOT_T);
          closed = component_char(it.ch);
        end
      end
      default: begin
        sh_phase = ofip_pkg::PH_SKIP;
      end
    endcase

    // End of line closes a pending number, or breaks a half-built triad
    if (!closed && it.eol) begin
      if (sh_phase == ofip_pkg::PH_DIGITS) closed = 1'b1;
      else if (sh_phase != ofip_pkg::PH_BETWEEN && sh_phase != ofip_pkg::PH_SKIP)
        flag_error(ofip_pkg::ST_EXPECT_INT);
    end

    if (closed && close_triad(it, r)) give = 1'b1;
    r.triad_total = sh_triads;

    if (it.eol) begin
      st = sh_err;
      if (st == ofip_pkg::ST_OK && sh_triads < ofip_pkg::MIN_TRIADS) st = ofip_pkg::ST_EXPECT_INT;
      r.line_done   = 1'b1;
      r.line_status = st;
      give = 1'b1;
      clear_line();
    end
    if (give) face_results_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Line builders
  // ---------------------------------------------------------------------------
  function automatic logic [IDX_W-1:0] pick_count();
    int r;
    r = $urandom % 16;
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return IDX_W'($urandom);
    return IDX_W'($urandom_range(1, 40));
  endfunction

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic push_ws();
    line_buf.push_back(($urandom % 3 != 0) ? ofip_pkg::CH_SPACE : ws_chars[$urandom % 8]);
  endtask

  // Signed decimal component aimed around the given count
  task automatic push_component(logic [IDX_W-1:0] cnt);
    logic [63:0] m;
    int r;
    r = $urandom % 8;
    if (r == 0) line_buf.push_back(ofip_pkg::CH_MINUS);
    else if (r == 1) line_buf.push_back(ofip_pkg::CH_PLUS);
    r = $urandom % 20;
    case (r)
      0:       m = 64'd0;
      1:       m = 64'(cnt) + 64'd1;
      2:       m = MAG_MAX;
      3:       m = MAG_MAX + 64'd1;
      4:       m = 64'($urandom) * 64'd1000 + 64'($urandom % 1000);
      5:       m = 64'(cnt);
      default: m = (cnt == 0) ? 64'd1 : 64'($urandom_range(1, (cnt < 40) ? int'(cnt) : 40));
    endcase
    if ($urandom % 10 == 0) line_buf.push_back(ofip_pkg::CH_ZERO);
    push_text($sformatf("%0d", m));
  endtask

  // Moves the built line into the character stream, eol on its last beat
  task automatic emit_line(logic [IDX_W-1:0] vc, logic [IDX_W-1:0] tc,
                           logic [IDX_W-1:0] nc, bit vary);
    face_char_t it;
    for (int i = 0; i < line_buf.size(); i++) begin
      it.ch  = line_buf[i];
      it.eol = (i == line_buf.size() - 1);
      it.vc  = (vary && $urandom % 3 == 0) ? pick_count() : vc;
      it.tc  = (vary && $urandom % 3 == 0) ? pick_count() : tc;
      it.nc  = (vary && $urandom % 3 == 0) ? pick_count() : nc;
      char_stream.push_back(it);
    end
    line_buf.delete();
    lines_built++;
  endtask

  // Random face line: mostly well-formed triads, some junk and broken tails
  task automatic gen_line();
    int n_triads, form, f, r, cut;
    logic [IDX_W-1:0] vc, tc, nc;
    bit vary;
    line_buf.delete();
    vc   = pick_count();
    tc   = pick_count();
    nc   = pick_count();
    vary = ($urandom % 10 == 0);
    if ($urandom % 100 < 8) begin
      repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom % 5 == 0) push_ws();
      n_triads = ($urandom % 8 == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      form = $urandom % 4;
      for (int k = 0; k < n_triads; k++) begin
        if (k > 0) begin
          push_ws();
          if ($urandom % 4 == 0) push_ws();
        end
        f = ($urandom % 12 == 0) ? ($urandom % 4) : form;
        push_component(vc);
        if (f == 1 || f == 3) begin
          line_buf.push_back(ofip_pkg::CH_SLASH);
          push_component(tc);
        end
        if (f == 2) begin
          line_buf.push_back(ofip_pkg::CH_SLASH);
          line_buf.push_back(ofip_pkg::CH_SLASH);
          push_component(nc);
        end
        if (f == 3) begin
          line_buf.push_back(ofip_pkg::CH_SLASH);
          push_component(nc);
        end
        r = $urandom % 30;
        if (r == 0) line_buf.push_back(ofip_pkg::CH_SLASH);
        else if (r == 1) line_buf.push_back(8'($urandom_range(0, 255)));
        else if (r == 2)
          line_buf.push_back(($urandom % 2) ? ofip_pkg::CH_PLUS : ofip_pkg::CH_MINUS);
      end
      if ($urandom % 5 == 0) push_ws();
      if ($urandom % 12 == 0 && line_buf.size() > 1) begin
        cut = $urandom_range(0, line_buf.size() - 2);
        line_buf = line_buf[0:cut];
      end
    end
    if (line_buf.size() == 0) push_ws();
    emit_line(vc, tc, nc, vary);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers pending beats and predicts each accepted one
  // ---------------------------------------------------------------------------
  function automatic bit quiet_window();
    return calm || ((chars_taken / 64) % 5 == 4);
  endfunction

  always @(posedge clk_i) begin
    face_char_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        nxt = '{char_code_i, end_of_line_i, vertex_count_i, texcoord_count_i,
                normal_count_i};
        parse_face_char(nxt);
        chars_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (char_stream.size() > 0) begin
          nxt = char_stream.pop_front();
          char_code_i      <= nxt.ch;
          end_of_line_i    <= nxt.eol;
          vertex_count_i   <= nxt.vc;
          texcoord_count_i <= nxt.tc;
          normal_count_i   <= nxt.nc;
          in_valid_i       <= 1'b1;
          if (!quiet_window() && $urandom % 6 == 0) send_gap = $urandom_range(1, 4);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      calm <= (char_stream.size() < 120);
    end
  end

  // Long receiver hold-off once, mid-run, so the block backs up into its input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && chars_taken >= 300) begin
      hold_left <= 60;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    face_res_t exp_r;
    bit stall_now;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (face_results_q.size() == 0) begin
          $error("result beat with no prediction pending");
          err_count++;
        end else begin
          exp_r = face_results_q.pop_front();
          check_field("triad_valid", exp_r.triad_valid, triad_valid_o);
          check_field("vertex_index", exp_r.vertex_index, vertex_index_o);
          check_field("texcoord_index", exp_r.texcoord_index, texcoord_index_o);
          check_field("normal_index", exp_r.normal_index, normal_index_o);
          check_field("has_texcoord", exp_r.has_texcoord, has_texcoord_o);
          check_field("has_normal", exp_r.has_normal, has_normal_o);
          check_field("line_done", exp_r.line_done, line_done_o);
          check_field("line_status", exp_r.line_status, line_status_o);
          check_field("triad_total", exp_r.triad_total, triad_total_o);
          results_seen++;
          if (exp_r.triad_valid) triads_seen++;
          if (exp_r.line_done && exp_r.line_status != ofip_pkg::ST_OK) bad_lines++;
        end
      end
      // random stall bursts, none in the quiet stretches
      stall_now = 1'b0;
      if (stall_left > 0) begin
        stall_left--;
        stall_now = 1'b1;
      end else if (!quiet_window() && $urandom % 5 == 0) begin
        stall_left = $urandom_range(0, 3);
        stall_now = 1'b1;
      end
      out_stall_i <= stall_now || (hold_left != 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int base;
    clear_line();

    // directed: extreme counts, signs, trailing slash, zero, out of range,
    // kind mismatch, double sign, extra slash
    push_text("1 -1 +1");
    emit_line('1, '1, '1, 1'b0);
    push_text("1/");
    emit_line(24'd5, 24'd5, 24'd5, 1'b0);
    push_text("0");
    emit_line(24'd5, 24'd5, 24'd5, 1'b0);
    push_text("9");
    emit_line(24'd3, 24'd3, 24'd3, 1'b0);
    push_text("1//1 1");
    emit_line(24'd2, 24'd2, 24'd2, 1'b0);
    push_text("+-");
    emit_line(24'd2, 24'd2, 24'd2, 1'b0);
    push_text("1/1/1/");
    emit_line(24'd2, 24'd2, 24'd2, 1'b0);

    // one line long enough to saturate the triad total
    repeat (258) push_text("1 ");
    emit_line(24'd1, 24'd0, 24'd0, 1'b0);

    base = char_stream.size();
    while (char_stream.size() - base < 360) gen_line();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (char_stream.size() != 0 || in_valid_i) @(posedge clk_i);
    while (face_results_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("tb: %0d characters over %0d face lines, %0d result beats checked",
             chars_taken, lines_built, results_seen);
    $display("tb: %0d triads resolved, %0d lines closed with a nonzero status",
             triads_seen, bad_lines);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
